// ===== rtl/core/rws_pkg.sv =====
package rws_pkg;

   // Fixed field widths
   localparam int IDX_W        = 6;
   localparam int FIT_W        = 32;
   localparam int TOT_W        = 38;
   localparam int FRAC_W       = 16;
   localparam int SRC_W        = 2;
   localparam int CNT_W        = 7;
   localparam int DEF_W        = 56;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 56;
   localparam int GENOME_MAX_W = 64;
   localparam int IDX_SPAN     = 1 << IDX_W;

   // Running sum: slice below 2^38 plus up to 64 fitness values below 2^32
   localparam int ACC_W        = 40;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_SELECT = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [SRC_W-1:0] {
      SRC_WHEEL   = 2'd0,
      SRC_ENTRY0  = 2'd1,
      SRC_DEFAULT = 2'd2
   } src_type;

   localparam logic [CSR_IDX_W-1:0] CSR_POP_SIZE       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_GENOME = 4'd1;

   localparam logic [CNT_W-1:0] POP_SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_WALK,
      ST_FALL
   } state_type;

   typedef struct packed {
      logic capture;
      logic init;
      logic add;
   } acc_ctl_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic rd_en;
   } tab_ctl_type;

endpackage

// ===== rtl/core/rws_accum.sv =====
module rws_accum import rws_pkg::*; (
   input  logic              clock,
   input  acc_ctl_type       ctl,
   input  logic [TOT_W-1:0]  total,
   input  logic [FRAC_W-1:0] frac,
   input  logic [FIT_W-1:0]  fitness,
   output logic              hit
);

   logic [TOT_W-1:0]        total_ff;
   logic [FRAC_W-1:0]       frac_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [ACC_W-1:0]        acc_in;
   logic [TOT_W+FRAC_W-1:0] product;
   logic [ACC_W-1:0]        sum;

   // Slice product, then running sum of the live fitness values
   assign product = (TOT_W+FRAC_W)'(total_ff) * (TOT_W+FRAC_W)'(frac_ff);
   assign sum     = acc_ff + ACC_W'(fitness);
   assign hit     = ACC_W'(total_ff) < sum;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.init) begin
         acc_in = ACC_W'(product[TOT_W+FRAC_W-1:FRAC_W]);
      end else if (ctl.add) begin
         acc_in = sum;
      end
   end

   // Operand hold for the select, plus the running sum register
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         total_ff <= total;
         frac_ff  <= frac;
      end
      acc_ff <= acc_in;
   end

endmodule

// ===== rtl/core/rws_table.sv =====
module rws_table import rws_pkg::*; #(
   parameter int TAB_DEPTH   = 64,
   parameter int TAB_AW      = 6,
   parameter int GENOME_BITS = 56
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tab_ctl_type            ctl,
   input  logic [TAB_AW-1:0]      waddr,
   input  logic [FIT_W-1:0]       wfit,
   input  logic [GENOME_BITS-1:0] wgenome,
   input  logic [TAB_AW-1:0]      raddr,
   output logic [FIT_W-1:0]       rd_fit,
   output logic [GENOME_BITS-1:0] rd_genome,
   output logic                   rd_valid,
   output logic                   rd_live,
   output logic                   last_live
);

   logic [FIT_W-1:0]       fit_mem [TAB_DEPTH];
   logic [GENOME_BITS-1:0] gen_mem [TAB_DEPTH];

   logic [TAB_DEPTH-1:0]   valid_ff;
   logic [TAB_DEPTH-1:0]   live_ff;
   logic [CNT_W-1:0]       loaded_ff;
   logic [CNT_W-1:0]       loaded_in;
   logic [CNT_W-1:0]       last_cnt;
   logic [CNT_W-1:0]       cover_cnt;

   logic [FIT_W-1:0]       rd_fit_ff;
   logic [GENOME_BITS-1:0] rd_genome_ff;
   logic                   rd_valid_ff;
   logic                   rd_live_ff;

   // Grow the table length to cover a newly loaded slot
   assign cover_cnt = CNT_W'(waddr) + CNT_W'(1);

   always_comb begin
      loaded_in = loaded_ff;
      if (ctl.clear) begin
         loaded_in = '0;
      end else if (ctl.load && (loaded_ff < cover_cnt)) begin
         loaded_in = cover_cnt;
      end
   end

   // Last slot is live when loaded with non-zero fitness
   assign last_cnt  = loaded_ff - CNT_W'(1);
   assign last_live = (loaded_ff != '0) && live_ff[last_cnt[TAB_AW-1:0]];

   // Valid and live bits: cleared at once by reset or a clear beat
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff  <= '0;
         live_ff   <= '0;
         loaded_ff <= '0;
      end else begin
         loaded_ff <= loaded_in;
         if (ctl.load) begin
            valid_ff[waddr] <= 1'b1;
            live_ff[waddr]  <= (wfit != '0);
         end
      end
   end

   // Entry store
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         fit_mem[waddr] <= wfit;
         gen_mem[waddr] <= wgenome;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_fit_ff    <= fit_mem[raddr];
         rd_genome_ff <= gen_mem[raddr];
         rd_valid_ff  <= valid_ff[raddr];
         rd_live_ff   <= live_ff[raddr];
      end
   end

   assign rd_fit    = rd_fit_ff;
   assign rd_genome = rd_genome_ff;
   assign rd_valid  = rd_valid_ff;
   assign rd_live   = rd_live_ff;

endmodule

// ===== rtl/core/rws_seq.sv =====
module rws_seq import rws_pkg::*; #(
   parameter int TAB_DEPTH   = 64,
   parameter int TAB_AW      = 6,
   parameter int GENOME_BITS = 56
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             kind,
   input  logic [IDX_W-1:0]       entry_index,
   input  logic [CNT_W-1:0]       pop_size,
   input  logic [DEF_W-1:0]       default_genome,
   output logic                   busy,
   output tab_ctl_type            tab_ctl,
   output logic [TAB_AW-1:0]      waddr,
   output logic [TAB_AW-1:0]      raddr,
   output acc_ctl_type            acc_ctl,
   input  logic                   hit,
   input  logic [GENOME_BITS-1:0] rd_genome,
   input  logic                   rd_valid,
   input  logic                   rd_live,
   input  logic                   last_live,
   output logic                   rsp_valid,
   output logic [GENOME_BITS-1:0] rsp_genome,
   output logic [SRC_W-1:0]       rsp_source,
   output logic [IDX_W-1:0]       rsp_index
);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic                   pend_ff, pend_in;
   logic [TAB_AW-1:0]      pend_idx_ff, pend_idx_in;

   logic                   rsp_valid_ff;
   logic [GENOME_BITS-1:0] rsp_genome_ff;
   logic [SRC_W-1:0]       rsp_source_ff;
   logic [IDX_W-1:0]       rsp_index_ff;

   logic                   emit;
   logic [GENOME_BITS-1:0] emit_genome;
   src_type                emit_source;
   logic [IDX_W-1:0]       emit_index;

   logic [CNT_W-1:0]        limit;
   logic                    index_ok;
   logic [GENOME_MAX_W-1:0] def_wide;
   logic [GENOME_BITS-1:0]  def_genome;

   assign busy     = (state_ff != ST_IDLE);
   assign waddr    = entry_index[TAB_AW-1:0];
   assign index_ok = CNT_W'(entry_index) < CNT_W'(TAB_DEPTH);
   assign limit    = (pop_size > CNT_W'(TAB_DEPTH)) ? CNT_W'(TAB_DEPTH) : pop_size;
   assign def_wide   = GENOME_MAX_W'(default_genome);
   assign def_genome = def_wide[GENOME_BITS-1:0];

   // State register and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      iss_ff      <= iss_in;
      pend_idx_ff <= pend_idx_in;
   end

   // Sequencer: slice multiply, walk one slot a cycle, then fallback
   always_comb begin
      state_in    = state_ff;
      iss_in      = iss_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      tab_ctl     = '0;
      acc_ctl     = '0;
      raddr       = iss_ff[TAB_AW-1:0];
      emit        = 1'b0;
      emit_genome = rd_genome;
      emit_source = SRC_WHEEL;
      emit_index  = IDX_W'(pend_idx_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (kind)
                  KIND_LOAD: begin
                     tab_ctl.load = index_ok;
                  end
                  KIND_CLEAR: begin
                     tab_ctl.clear = 1'b1;
                  end
                  KIND_SELECT: begin
                     acc_ctl.capture = 1'b1;
                     state_in        = ST_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_MUL: begin
            acc_ctl.init = 1'b1;
            raddr        = '0;
            pend_idx_in  = '0;
            iss_in       = '0;
            pend_in      = 1'b0;
            if (limit != '0) begin
               tab_ctl.rd_en = 1'b1;
               iss_in        = CNT_W'(1);
               pend_in       = 1'b1;
            end
            state_in = ST_WALK;
         end

         ST_WALK: begin
            acc_ctl.add = pend_ff && rd_live;
            if (pend_ff && rd_live && hit) begin
               // Wheel pick on this slot
               emit     = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (pend_ff) begin
               pend_in = 1'b0;
               if (iss_ff < limit) begin
                  tab_ctl.rd_en = 1'b1;
                  iss_in        = iss_ff + CNT_W'(1);
                  pend_in       = 1'b1;
                  pend_idx_in   = iss_ff[TAB_AW-1:0];
               end
            end else begin
               // Walk done without a pick: fetch slot zero for the fallback
               tab_ctl.rd_en = 1'b1;
               raddr         = '0;
               state_in      = ST_FALL;
            end
         end

         ST_FALL: begin
            emit       = 1'b1;
            emit_index = '0;
            if (last_live) begin
               emit_genome = rd_valid ? rd_genome : '0;
               emit_source = SRC_ENTRY0;
            end else begin
               emit_genome = def_genome;
               emit_source = SRC_DEFAULT;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   // Result beat: one cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
      if (emit) begin
         rsp_genome_ff <= emit_genome;
         rsp_source_ff <= emit_source;
         rsp_index_ff  <= emit_index;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_genome = rsp_genome_ff;
   assign rsp_source = rsp_source_ff;
   assign rsp_index  = rsp_index_ff;

endmodule

// ===== rtl/core/roulette_wheel_selector_top.sv =====
// Roulette wheel selector. A beat is taken when start is high and busy is low. Load,
// clear and unused kinds complete in the cycle of the beat and leave busy low. A select raises
// busy for the slice multiply and a walk over the population table that reads one slot
// a cycle through the single table read port and adds its fitness in the shared
// accumulator: a pick ends the walk at that slot, and a select with no pick walks limit
// slots, where limit is population_size capped at the table depth, then falls back to
// entry zero or the default genome. Each result is on the rsp_ ports for exactly
// one cycle marked by rsp_valid, the cycle in which busy falls again; the receiver cannot
// stall it, so capture it then. Reset and clear empty the table at once, with no clearing
// pass. Configuration writes are always ready and are meant to be made while busy is low.
module roulette_wheel_selector_top import rws_pkg::*; #(
   parameter int POP_DEPTH   = 64,
   parameter int GENOME_BITS = 56
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_kind,
   input  logic [IDX_W-1:0]       req_entry_index,
   input  logic [FIT_W-1:0]       req_entry_fitness,
   input  logic [GENOME_BITS-1:0] req_entry_genome,
   input  logic [TOT_W-1:0]       req_total_fitness,
   input  logic [FRAC_W-1:0]      req_random_fraction,
   output logic                   rsp_valid,
   output logic [GENOME_BITS-1:0] rsp_chosen_genome,
   output logic [SRC_W-1:0]       rsp_pick_source,
   output logic [IDX_W-1:0]       rsp_chosen_index,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Only slots reachable by the entry index are stored
   localparam int TAB_DEPTH = (POP_DEPTH < IDX_SPAN) ? POP_DEPTH : IDX_SPAN;
   localparam int TAB_AW    = $clog2(TAB_DEPTH);

   logic [CNT_W-1:0]       pop_size_ff;
   logic [DEF_W-1:0]       default_ff;

   tab_ctl_type            tab_ctl;
   acc_ctl_type            acc_ctl;
   logic [TAB_AW-1:0]      waddr;
   logic [TAB_AW-1:0]      raddr;
   logic [FIT_W-1:0]       rd_fit;
   logic [GENOME_BITS-1:0] rd_genome;
   logic                   rd_valid;
   logic                   rd_live;
   logic                   last_live;
   logic                   hit;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_size_ff <= POP_SIZE_RESET;
         default_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POP_SIZE:       pop_size_ff <= csr_data[CNT_W-1:0];
            CSR_DEFAULT_GENOME: default_ff  <= csr_data[DEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rws_seq #(
      .TAB_DEPTH   (TAB_DEPTH),
      .TAB_AW      (TAB_AW),
      .GENOME_BITS (GENOME_BITS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .kind           (req_kind),
      .entry_index    (req_entry_index),
      .pop_size       (pop_size_ff),
      .default_genome (default_ff),
      .busy           (busy),
      .tab_ctl        (tab_ctl),
      .waddr          (waddr),
      .raddr          (raddr),
      .acc_ctl        (acc_ctl),
      .hit            (hit),
      .rd_genome      (rd_genome),
      .rd_valid       (rd_valid),
      .rd_live        (rd_live),
      .last_live      (last_live),
      .rsp_valid      (rsp_valid),
      .rsp_genome     (rsp_chosen_genome),
      .rsp_source     (rsp_pick_source),
      .rsp_index      (rsp_chosen_index)
   );

   rws_table #(
      .TAB_DEPTH   (TAB_DEPTH),
      .TAB_AW      (TAB_AW),
      .GENOME_BITS (GENOME_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tab_ctl),
      .waddr     (waddr),
      .wfit      (req_entry_fitness),
      .wgenome   (req_entry_genome),
      .raddr     (raddr),
      .rd_fit    (rd_fit),
      .rd_genome (rd_genome),
      .rd_valid  (rd_valid),
      .rd_live   (rd_live),
      .last_live (last_live)
   );

   rws_accum u_accum (
      .clock   (clock),
      .ctl     (acc_ctl),
      .total   (req_total_fitness),
      .frac    (req_random_fraction),
      .fitness (rd_fit),
      .hit     (hit)
   );

endmodule

// ===== rtl/core/rws_checker.sv =====
module rws_checker import rws_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_kind,
   input logic               rsp_valid,
   input logic [SRC_W-1:0]   rsp_pick_source,
   input logic [IDX_W-1:0]   rsp_chosen_index
);

   // A result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result comes only as the select finishes
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // A select beat occupies the block
   a_select_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_SELECT)) |=> busy)
      else $error("select beat did not raise busy");

   // Load and clear beats complete in their own cycle and give no result
   a_table_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_kind == KIND_LOAD) || (req_kind == KIND_CLEAR)))
      |=> (!busy && !rsp_valid))
      else $error("table beat raised busy or a result");

   // Fallback picks always carry index zero
   a_fallback_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_pick_source != SRC_WHEEL)) |-> (rsp_chosen_index == '0))
      else $error("fallback result with non-zero index");

endmodule

bind roulette_wheel_selector_top rws_checker u_rws_checker (.*);
